// ===== src/white_pixel_centroid_steer_core_macros.svh =====
// Assertion macros shared by the checker of the centroid steering core
`ifndef WHITE_PIXEL_CENTROID_STEER_CORE_MACROS_SVH
`define WHITE_PIXEL_CENTROID_STEER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define WPCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define WPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== src/wpcs_pkg.sv =====
// Shared types and constants of the white pixel centroid steering core
package wpcs_pkg;

    localparam int COLOR_W   = 8;
    localparam int FW_W      = 13;
    localparam int DIR_W     = 2;
    localparam int PCT_W     = 7;

    localparam logic [COLOR_W-1:0] WHITE_LEVEL = 8'd255;
    localparam logic [FW_W-1:0]    FW_RESET    = 13'd640;
    localparam logic [FW_W-1:0]    FW_LIMIT    = 13'd8191;
    localparam logic [PCT_W-1:0]   PCT_SCALE   = 7'd100;
    localparam logic [PCT_W-1:0]   LEFT_PCT    = 7'd33;
    localparam logic [PCT_W-1:0]   RIGHT_PCT   = 7'd66;

    localparam logic [DIR_W-1:0] DIR_STOP  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_AHEAD = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic pix_ready;
        logic pix_take;
        logic div_step;
        logic res_load;
    } wpcs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pix_valid;
        logic pix_last;
        logic res_busy;
    } wpcs_stat_t;

endpackage

// ===== src/wpcs_pixel_if.sv =====
// Pixel request channel: RGB pixel plus end-of-frame mark
interface wpcs_pixel_if
    import wpcs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               frame_end;

    modport source (output valid, output red, output green, output blue,
                    output frame_end, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_end, output ready);
endinterface

// ===== src/wpcs_result_if.sv =====
// Result request channel: steering code, centre column and white count
interface wpcs_result_if
    import wpcs_pkg::*;
#(
    parameter int COL_W = 12,
    parameter int CNT_W = 24
)();
    logic             valid;
    logic             ready;
    logic [DIR_W-1:0] direction;
    logic [COL_W-1:0] centre_column;
    logic [CNT_W-1:0] white_total;

    modport source (output valid, output direction, output centre_column,
                    output white_total, input ready);
    modport sink   (input valid, input direction, input centre_column,
                    input white_total, output ready);
endinterface

// ===== src/white_pixel_centroid_steer_core.sv =====
// Top level of the white pixel centroid steering core
//
// Takes one RGB pixel per clock in raster order, tracks its column against
// frame_width (clamped into 1..MAX_WIDTH, at most FW_LIMIT) and sums the
// columns of pure white pixels. The pixel marked frame_end closes the frame:
// the pixel channel then stays not ready while a one-bit-per-cycle restoring
// divider forms the mean column and the steering compare runs, longer if the
// previous result has not yet been taken. All other pixels are taken at one
// per clock, also while a result waits in the output register. One result
// follows each frame: stop with centre 0 when no white pixel was seen, else
// left, ahead or right from the mean against 33 % and 66 % of the width. The
// white count saturates at MAX_PIXELS-1.
// Write frame_width only between frames, after the last result is out.
module white_pixel_centroid_steer_core
    import wpcs_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter longint unsigned MAX_PIXELS = 64'd16777216
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [FW_W-1:0] cfg_wr_data,
    wpcs_pixel_if.sink      pixel,
    wpcs_result_if.source   result
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W     = $clog2(MAX_PIXELS);
    localparam int WIDTH_CAP = (MAX_WIDTH < int'(FW_LIMIT)) ? MAX_WIDTH : int'(FW_LIMIT);
    localparam longint unsigned CNT_CAP = MAX_PIXELS - 64'd1;

    wpcs_cmd_t  cmd;
    wpcs_stat_t stat;

    wpcs_ctrl #(
        .COL_W (COL_W)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    wpcs_datapath #(
        .COL_W     (COL_W),
        .CNT_W     (CNT_W),
        .WIDTH_CAP (WIDTH_CAP),
        .CNT_CAP   (CNT_CAP)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .pix_valid     (pixel.valid),
        .pix_red       (pixel.red),
        .pix_green     (pixel.green),
        .pix_blue      (pixel.blue),
        .pix_last      (pixel.frame_end),
        .res_ready     (result.ready),
        .cmd           (cmd),
        .stat          (stat),
        .res_valid     (result.valid),
        .res_direction (result.direction),
        .res_centre    (result.centre_column),
        .res_total     (result.white_total)
    );

    assign pixel.ready = cmd.pix_ready;

endmodule

// ===== src/wpcs_ctrl.sv =====
// Controller: pixel accumulation, iterative division and result load sequencing
module wpcs_ctrl
    import wpcs_pkg::*;
#(
    parameter int COL_W = 12
)(
    input  logic       clk,
    input  logic       rst_n,
    input  wpcs_stat_t stat,
    output wpcs_cmd_t  cmd
);

    localparam int STEP_W = (COL_W > 1) ? $clog2(COL_W) : 1;

    localparam logic [1:0] ST_ACC   = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_STEER = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd.pix_ready = 1'b0;
        cmd.pix_take  = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.res_load  = 1'b0;
        unique case (state_reg)
            ST_ACC:
            begin
                cmd.pix_ready = 1'b1;
                cmd.pix_take  = stat.pix_valid;
                if (stat.pix_valid && stat.pix_last)
                begin
                    state_next = ST_DIV;
                    step_next  = STEP_W'(COL_W - 1);
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_STEER;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_STEER:
            begin
                // hold until the output register is free
                if (!stat.res_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== src/wpcs_datapath.sv =====
// Datapath: column tracking, white accumulation, restoring divider, steering
module wpcs_datapath
    import wpcs_pkg::*;
#(
    parameter int COL_W     = 12,
    parameter int CNT_W     = 24,
    parameter int WIDTH_CAP = 4096,
    parameter longint unsigned CNT_CAP = 64'd16777215
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [FW_W-1:0]    cfg_wr_data,
    input  logic               pix_valid,
    input  logic [COLOR_W-1:0] pix_red,
    input  logic [COLOR_W-1:0] pix_green,
    input  logic [COLOR_W-1:0] pix_blue,
    input  logic               pix_last,
    input  logic               res_ready,
    input  wpcs_cmd_t          cmd,
    output wpcs_stat_t         stat,
    output logic               res_valid,
    output logic [DIR_W-1:0]   res_direction,
    output logic [COL_W-1:0]   res_centre,
    output logic [CNT_W-1:0]   res_total
);

    localparam int SUM_W = COL_W + CNT_W;
    localparam int CMP_W = ((COL_W > FW_W) ? COL_W : FW_W) + 1;
    localparam int PRD_W = ((COL_W > FW_W) ? COL_W : FW_W) + PCT_W;

    logic [FW_W-1:0]  fw_reg;
    logic [FW_W-1:0]  w_eff;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             is_white;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] dsh_reg;
    logic [COL_W-1:0] quo_reg;
    logic [CNT_W-1:0] tot_reg;
    logic             fits;
    logic [PRD_W-1:0] centre_scaled;
    logic [PRD_W-1:0] left_lim;
    logic [PRD_W-1:0] right_lim;
    logic [DIR_W-1:0] dir_calc;
    logic [COL_W-1:0] centre_calc;
    logic             out_valid_reg;
    logic [DIR_W-1:0] out_dir_reg;
    logic [COL_W-1:0] out_centre_reg;
    logic [CNT_W-1:0] out_total_reg;

    // Saturate the configured width into 1..cap
    always_comb
    begin
        priority if (fw_reg == '0)
            w_eff = FW_W'(1);
        else if (CMP_W'(fw_reg) > CMP_W'(WIDTH_CAP))
            w_eff = FW_W'(WIDTH_CAP);
        else
            w_eff = fw_reg;
    end

    assign is_white = (pix_red == WHITE_LEVEL) && (pix_green == WHITE_LEVEL)
                      && (pix_blue == WHITE_LEVEL) && (cnt_reg < CNT_W'(CNT_CAP));

    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        if (is_white)
        begin
            cnt_next = cnt_reg + 1'b1;
            sum_next = sum_reg + SUM_W'(col_reg);
        end
        if ((CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(w_eff))
            col_next = '0;
        else
            col_next = col_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= FW_RESET;
            col_reg <= '0;
            cnt_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                fw_reg <= cfg_wr_data;
            if (cmd.pix_take)
            begin
                if (pix_last)
                begin
                    // clear for the next frame
                    col_reg <= '0;
                    cnt_reg <= '0;
                    sum_reg <= '0;
                end
                else
                begin
                    col_reg <= col_next;
                    cnt_reg <= cnt_next;
                    sum_reg <= sum_next;
                end
            end
        end
    end

    // Restoring divider: the mean is below the width, so COL_W quotient bits suffice
    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.pix_take && pix_last)
        begin
            rem_reg <= sum_next;
            dsh_reg <= SUM_W'(cnt_next) << (COL_W - 1);
            quo_reg <= '0;
            tot_reg <= cnt_next;
        end
        else if (cmd.div_step)
        begin
            if (fits)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= (quo_reg << 1) | COL_W'(fits);
        end
    end

    assign centre_scaled = PRD_W'(quo_reg) * PRD_W'(PCT_SCALE);
    assign left_lim      = PRD_W'(w_eff) * PRD_W'(LEFT_PCT);
    assign right_lim     = PRD_W'(w_eff) * PRD_W'(RIGHT_PCT);

    always_comb
    begin
        centre_calc = quo_reg;
        priority if (tot_reg == '0)
        begin
            dir_calc    = DIR_STOP;
            centre_calc = '0;
        end
        else if (centre_scaled < left_lim)
            dir_calc = DIR_LEFT;
        else if (centre_scaled > right_lim)
            dir_calc = DIR_RIGHT;
        else
            dir_calc = DIR_AHEAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_load)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_dir_reg    <= dir_calc;
            out_centre_reg <= centre_calc;
            out_total_reg  <= tot_reg;
        end
    end

    assign stat.pix_valid = pix_valid;
    assign stat.pix_last  = pix_last;
    assign stat.res_busy  = out_valid_reg && !res_ready;

    assign res_valid     = out_valid_reg;
    assign res_direction = out_dir_reg;
    assign res_centre    = out_centre_reg;
    assign res_total     = out_total_reg;

endmodule

// ===== src/wpcs_checker.sv =====
// Port-level checker of the centroid steering core, bound to the top level
`include "white_pixel_centroid_steer_core_macros.svh"

module wpcs_checker
    import wpcs_pkg::*;
#(
    parameter int COL_W = 12,
    parameter int CNT_W = 24
)(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             in_last,
    input logic             out_valid,
    input logic             out_ready,
    input logic [DIR_W-1:0] out_dir,
    input logic [COL_W-1:0] out_centre,
    input logic [CNT_W-1:0] out_total
);

    // a stalled result must not change
    `WPCS_ASSERT_NEXT(a_res_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_dir) && $stable(out_centre) && $stable(out_total))

    // stop exactly when no white pixel was counted
    `WPCS_ASSERT_NOW(a_stop_empty, clk, rst_n, out_valid, (out_dir == DIR_STOP) == (out_total == '0))

    // an empty frame reports centre zero
    `WPCS_ASSERT_NOW(a_stop_centre, clk, rst_n, out_valid && (out_total == '0), out_centre == '0)

    // closing a frame drops ready while the divider runs
    `WPCS_ASSERT_NEXT(a_end_stall, clk, rst_n, in_valid && in_ready && in_last, !in_ready)

endmodule

bind white_pixel_centroid_steer_core wpcs_checker #(
    .COL_W (COL_W),
    .CNT_W (CNT_W)
) u_wpcs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pixel.valid),
    .in_ready   (pixel.ready),
    .in_last    (pixel.frame_end),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_dir    (result.direction),
    .out_centre (result.centre_column),
    .out_total  (result.white_total)
);
